// ===== src/apd_pkg.sv =====
// ----------------------------------------------------------------------------
// apd_pkg: shared types and constants of the averaged PID drive
// Holds the fixed field widths, the register indexes, the sequencer states
// and the control bundle that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package apd_pkg;

  // Fixed widths of the register and result fields.
  localparam int SP_W       = 12;
  localparam int GAIN_W     = 24;
  localparam int SUM_W      = 24;
  localparam int DRIVE_W    = 16;
  localparam int AVG_OUT_W  = 12;
  localparam int RERR_W     = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // The shared multiplier is signed, one bit wider than a gain.
  localparam int MUL_W   = GAIN_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  // Gains are Q8.16; the final product is built from 16-bit chunks.
  localparam int FRAC_W  = 16;
  localparam int CHUNK_W = 16;
  // Partial sums of gain times chunk stay below 2^41.
  localparam int ACC_W   = GAIN_W + CHUNK_W + 2;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = '1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DER_GAIN  = CFG_IDX_W'(3);

  // Sequencer states: idle, stop, and one multiplier slot per step of a run.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STOP,
    ST_DIVM,
    ST_DIVQ,
    ST_FIX,
    ST_ERR,
    ST_DER,
    ST_ACC,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_K3
  } state_e;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    state_e state;
    logic   take_run;
    logic   take_stop;
    logic   finish;
  } ctrl_t;

endpackage

// ===== src/apd_if.sv =====
// ----------------------------------------------------------------------------
// apd_if: channel interfaces of the averaged PID drive
// Sample input, result output and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface apd_in_if #(
  parameter int SampleBits = 12
) ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [SampleBits-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface apd_out_if
  import apd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DRIVE_W-1:0]       drive;
  logic [AVG_OUT_W-1:0]     average;
  logic signed [RERR_W-1:0] report_error;

  modport source (output valid, output drive, output average, output report_error,
                  input ready);
  modport sink   (input valid, input drive, input average, input report_error,
                  output ready);
endinterface

interface apd_cfg_if
  import apd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/apd_window.sv =====
// ----------------------------------------------------------------------------
// apd_window: sample window with running total
// Shift line of the last WINDOW samples; the total is kept up to date by
// subtracting the sample that drops out and adding the one that comes in.
// ----------------------------------------------------------------------------
module apd_window
  import apd_pkg::*;
#(
  parameter int WINDOW      = 6,
  parameter int SAMPLE_BITS = 12,
  parameter int TOT_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [TOT_W-1:0]       total_o
);

  logic [SAMPLE_BITS-1:0] taps_q [WINDOW];
  logic [TOT_W-1:0]       total_q;
  logic [TOT_W-1:0]       total_d;

  // Oldest sample leaves, newest enters.
  assign total_d = total_q - TOT_W'(taps_q[0]) + TOT_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        taps_q[i] <= '0;
      end
    end else if (shift_i) begin
      total_q <= total_d;
      for (int i = 0; i < WINDOW - 1; i++) begin
        taps_q[i] <= taps_q[i+1];
      end
      taps_q[WINDOW-1] <= sample_i;
    end
  end

  assign total_o = total_q;

endmodule

// ===== src/apd_mul.sv =====
// ----------------------------------------------------------------------------
// apd_mul: shared signed multiplier
// One signed MUL_W by MUL_W multiplier with a registered product, used by
// every multiply step of the sequence.
// ----------------------------------------------------------------------------
module apd_mul
  import apd_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  // Both operands are signed, so the full product is exact in PROD_W bits.
  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== src/apd_ctrl.sv =====
// ----------------------------------------------------------------------------
// apd_ctrl: sequencer of the averaged PID drive
// Steps one accepted transaction through the multiplier slots and waits in
// the last state until the output register is free.
// ----------------------------------------------------------------------------
module apd_ctrl
  import apd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_cmd_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e state_q;
  state_e state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_d          = state_q;
    ctrl_o.state     = state_q;
    ctrl_o.take_run  = 1'b0;
    ctrl_o.take_stop = 1'b0;
    ctrl_o.finish    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i) begin
            ctrl_o.take_stop = 1'b1;
            state_d          = ST_STOP;
          end else begin
            ctrl_o.take_run = 1'b1;
            state_d         = ST_DIVM;
          end
        end
      end
      ST_STOP, ST_K3: begin
        if (out_free_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DIVM: state_d = ST_DIVQ;
      ST_DIVQ: state_d = ST_FIX;
      ST_FIX:  state_d = ST_ERR;
      ST_ERR:  state_d = ST_DER;
      ST_DER:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_K0;
      ST_K0:   state_d = ST_K1;
      ST_K1:   state_d = ST_K2;
      ST_K2:   state_d = ST_K3;
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/averaged_pid_drive.sv =====
// ----------------------------------------------------------------------------
// averaged_pid_drive: PID drive stage behind a moving-average filter
// Averages the last WINDOW sensor samples, forms the error against the
// setpoint and computes a clamped, saturated PID drive in Q8.16 gains.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one transaction per control tick: cmd (0 run, 1 stop) and
//   the raw sample. out_o returns one result per transaction: drive,
//   average and report_error (setpoint minus average). cfg_i writes the
//   setpoint and the three gains by index; write only while the block is
//   idle. cfg_i is always ready; unknown indexes are ignored.
//   A run transaction passes through the single shared 25x25 multiplier,
//   which is used in seven sequential steps (division by WINDOW, its
//   correction, the integral and derivative terms and three chunks of the
//   proportional gain). A stop transaction returns all zeros.
//   in_i is not ready while a transaction is being worked on. The result
//   sits in an output register; if the receiver stalls, the sequencer holds
//   its last step until the register is free, then returns to idle.
//   Reset clears the window, the error state, the configuration registers,
//   the sequencer and the output valid flag.
module averaged_pid_drive
  import apd_pkg::*;
#(
  parameter int WINDOW      = 6,
  parameter int SAMPLE_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  apd_in_if.sink     in_i,
  apd_out_if.source  out_o,
  apd_cfg_if.sink    cfg_i
);

  localparam int TOT_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam int MAXW  = (SAMPLE_BITS > SP_W) ? SAMPLE_BITS : SP_W;
  localparam int E_W   = MAXW + 1;
  localparam logic [TOT_W-1:0] RECIP = TOT_W'((2 ** TOT_W) / WINDOW);

  ctrl_t ctrl;

  logic [SP_W-1:0]   sp_q;
  logic [GAIN_W-1:0] kp_q;
  logic [GAIN_W-1:0] gi_q;
  logic [GAIN_W-1:0] gd_q;

  logic [TOT_W-1:0]       total;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [SAMPLE_BITS-1:0]   avg_q;
  logic signed [E_W-1:0]    e_q;
  logic signed [E_W-1:0]    last_err_q;
  logic signed [SUM_W-1:0]  err_sum_q;
  logic signed [PROD_W-1:0] inner_q;
  logic [ACC_W-1:0]         acc_q;

  logic [DRIVE_W-1:0]       drive_q;
  logic [AVG_OUT_W-1:0]     avg_out_q;
  logic signed [RERR_W-1:0] rerr_q;
  logic                     out_valid_q;
  logic                     out_free;

  logic [SAMPLE_BITS-1:0] quot;
  logic [TOT_W-1:0]       rem;
  logic [MAXW-1:0]        avg_wide;
  logic signed [E_W-1:0]  e_d;
  logic signed [E_W-1:0]  neg_e;
  logic signed [E_W:0]    diff;
  logic signed [SUM_W:0]  sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic [ACC_W-1:0]       acc_fin;
  logic                   inner_pos;
  logic [DRIVE_W-1:0]     drive_d;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      kp_q <= '0;
      gi_q <= '0;
      gd_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SETPOINT:  sp_q <= cfg_i.data[SP_W-1:0];
        REG_PROP_GAIN: kp_q <= cfg_i.data[GAIN_W-1:0];
        REG_INT_GAIN:  gi_q <= cfg_i.data[GAIN_W-1:0];
        REG_DER_GAIN:  gd_q <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (ctrl.state == ST_IDLE);

  apd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Sample window and running total.
  apd_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TOT_W       (TOT_W)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (ctrl.take_run),
    .sample_i (in_i.sample),
    .total_o  (total)
  );

  // Derived values used by the steps.
  assign quot     = prod[TOT_W+SAMPLE_BITS-1:TOT_W];
  assign rem      = total - prod[TOT_W-1:0];
  assign avg_wide = MAXW'(avg_q);
  assign e_d      = $signed({1'b0, avg_wide}) - $signed({1'b0, MAXW'(sp_q)});
  assign neg_e    = -e_q;
  assign diff     = (E_W+1)'(e_q) - (E_W+1)'(last_err_q);

  // Saturating update of the error sum.
  assign sum_ext = (SUM_W+1)'(err_sum_q) + (SUM_W+1)'(e_q);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // Final drive: floor(kp * inner / 2^32), clamped to DRIVE_MAX, zero for a non-positive inner sum.
  assign acc_fin   = (acc_q >> CHUNK_W) + prod[ACC_W-1:0];
  assign inner_pos = !inner_q[PROD_W-1] && (inner_q != '0);
  always_comb begin
    if (!inner_pos) begin
      drive_d = '0;
    end else if (|acc_fin[ACC_W-1:DRIVE_W]) begin
      drive_d = DRIVE_MAX;
    end else begin
      drive_d = acc_fin[DRIVE_W-1:0];
    end
  end

  // Operand selection for the shared multiplier. The top chunk stays
  // selected in the last step so the product holds while the output stalls.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.state)
      ST_DIVM: begin
        mul_a = $signed({{(MUL_W-TOT_W){1'b0}}, total});
        mul_b = $signed({{(MUL_W-TOT_W){1'b0}}, RECIP});
      end
      ST_DIVQ: begin
        mul_a = $signed({{(MUL_W-SAMPLE_BITS){1'b0}}, quot});
        mul_b = MUL_W'(WINDOW);
      end
      ST_FIX: begin
        mul_a = $signed({1'b0, gi_q});
        mul_b = MUL_W'(err_sum_q);
      end
      ST_DER: begin
        mul_a = $signed({1'b0, gd_q});
        mul_b = MUL_W'(diff);
      end
      ST_K0: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = $signed({{(MUL_W-CHUNK_W){1'b0}}, inner_q[CHUNK_W-1:0]});
      end
      ST_K1: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = $signed({{(MUL_W-CHUNK_W){1'b0}}, inner_q[2*CHUNK_W-1:CHUNK_W]});
      end
      ST_K2, ST_K3: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = $signed({{(MUL_W-CHUNK_W){1'b0}}, inner_q[3*CHUNK_W-1:2*CHUNK_W]});
      end
      default: ;
    endcase
  end

  apd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Datapath registers updated step by step.
  always_ff @(posedge clk_i) begin
    case (ctrl.state)
      ST_DIVQ: avg_q <= quot;
      ST_FIX: begin
        if (rem >= TOT_W'(WINDOW)) begin
          avg_q <= avg_q + 1'b1;
        end
      end
      ST_ERR: begin
        e_q     <= e_d;
        inner_q <= prod;
      end
      ST_DER:  inner_q <= inner_q + (PROD_W'(e_q) <<< FRAC_W);
      ST_ACC:  inner_q <= inner_q + prod;
      ST_K1:   acc_q   <= prod[ACC_W-1:0];
      ST_K2:   acc_q   <= (acc_q >> CHUNK_W) + prod[ACC_W-1:0];
      default: ;
    endcase
  end

  // Error state: cleared by stop, updated after the derivative term is formed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      last_err_q <= '0;
    end else if (ctrl.take_stop) begin
      err_sum_q  <= '0;
      last_err_q <= '0;
    end else if (ctrl.state == ST_ACC) begin
      err_sum_q  <= sum_sat;
      last_err_q <= e_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      if (ctrl.state == ST_STOP) begin
        drive_q   <= '0;
        avg_out_q <= '0;
        rerr_q    <= '0;
      end else begin
        drive_q   <= drive_d;
        avg_out_q <= avg_wide[AVG_OUT_W-1:0];
        rerr_q    <= neg_e[RERR_W-1:0];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive        = drive_q;
  assign out_o.average      = avg_out_q;
  assign out_o.report_error = rerr_q;

  // A stop transaction leaves the error state cleared.
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd) |=> (err_sum_q == '0 && last_err_q == '0))
    else $error("error state not cleared after stop");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after acceptance");

  // A stop result is all zeros.
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.finish && ctrl.state == ST_STOP) |=>
      (drive_q == '0 && avg_out_q == '0 && rerr_q == '0))
    else $error("stop result not zero");

  // A nonzero drive needs a nonzero proportional gain.
  a_drive_needs_kp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.finish && ctrl.state == ST_K3 && kp_q == '0) |=> drive_q == '0)
    else $error("drive nonzero with zero proportional gain");

  // A result is only produced when the output register can take it.
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> (!out_valid_q || out_o.ready))
    else $error("result overwrote a pending transaction");

endmodule

// ===== sim/apd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apd_checker: result checker for the averaged PID drive
// Watches the sample, result and configuration channels. Keeps its own copy
// of the registers, the sample window and the error state, works out the
// result of every accepted sample transaction and compares each returned
// result, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module apd_checker
  import apd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  apd_in_if    in_mon,
  apd_out_if   out_mon,
  apd_cfg_if   cfg_mon,
  output int   failures_o,
  output int   outstanding_o
);

  localparam int WINDOW      = 6;
  localparam int SAMPLE_BITS = 12;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic        [DRIVE_W-1:0]   drive;
    logic        [AVG_OUT_W-1:0] average;
    logic signed [RERR_W-1:0]    report_error;
  } drive_result_t;

  // Register copies.
  logic [SP_W-1:0]   sp_reg = '0;
  logic [GAIN_W-1:0] kp_reg = '0;
  logic [GAIN_W-1:0] gi_reg = '0;
  logic [GAIN_W-1:0] gd_reg = '0;

  // Filter and controller state.
  logic        [SAMPLE_BITS-1:0] sample_hist [WINDOW];
  logic signed [RERR_W-1:0]      err_prev = '0;
  logic signed [SUM_W-1:0]       err_acc  = '0;

  // Results of accepted samples that have not come back yet, oldest first.
  drive_result_t drive_results_q [$];
  drive_result_t oldest;
  int            mismatch_count = 0;

  assign failures_o    = mismatch_count;
  assign outstanding_o = drive_results_q.size();

  // One line per failure; printing stops after a while but counting goes on.
  task automatic flag_error(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SETPOINT:  sp_reg = value[SP_W-1:0];
      REG_PROP_GAIN: kp_reg = value[GAIN_W-1:0];
      REG_INT_GAIN:  gi_reg = value[GAIN_W-1:0];
      REG_DER_GAIN:  gd_reg = value[GAIN_W-1:0];
      default: ;  // Writes to unused indexes leave every register alone.
    endcase
  endtask

  // Advances the filter and controller by one sample and returns the result.
  function automatic drive_result_t compute_drive_step(
      input logic                   stop,
      input logic [SAMPLE_BITS-1:0] raw);
    drive_result_t r;
    int            i;
    int            total;
    int            err;
    int            next_acc;
    longint        inner;
    logic [95:0]   scaled;
    logic [AVG_OUT_W-1:0] avg;
    r = '0;
    // A stop clears the error state, keeps the window and returns zeros.
    if (stop) begin
      err_prev = '0;
      err_acc  = '0;
      return r;
    end
    for (i = 0; i < WINDOW - 1; i++) begin
      sample_hist[i] = sample_hist[i+1];
    end
    sample_hist[WINDOW-1] = raw;
    total = 0;
    for (i = 0; i < WINDOW; i++) begin
      total += int'(sample_hist[i]);
    end
    avg = AVG_OUT_W'(total / WINDOW);
    err = int'(avg) - int'(sp_reg);
    // Q.16 control value, using the accumulated error from before this step.
    inner = longint'(err) * 65536
          + longint'(gi_reg) * longint'(err_acc)
          + longint'(gd_reg) * (longint'(err) - longint'(err_prev));
    // Drive is the floor of kp * inner / 2^32, zero when not positive.
    if (inner > 0 && kp_reg != '0) begin
      scaled = 96'(inner) * 96'(kp_reg);
      scaled = scaled >> 32;
      r.drive = (scaled > 96'(DRIVE_MAX)) ? DRIVE_MAX : DRIVE_W'(scaled);
    end
    r.average      = avg;
    r.report_error = RERR_W'(-err);
    // Saturating accumulation of the error.
    next_acc = int'(err_acc) + err;
    if (next_acc > int'(SUM_MAX)) next_acc = int'(SUM_MAX);
    if (next_acc < int'(SUM_MIN)) next_acc = int'(SUM_MIN);
    err_acc  = SUM_W'(next_acc);
    err_prev = RERR_W'(err);
    return r;
  endfunction

  // Channel monitor: registers, then returned results, then new samples.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_reg   = '0;
      kp_reg   = '0;
      gi_reg   = '0;
      gd_reg   = '0;
      err_prev = '0;
      err_acc  = '0;
      for (int i = 0; i < WINDOW; i++) begin
        sample_hist[i] = '0;
      end
      drive_results_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        apply_register(cfg_mon.index, cfg_mon.data);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (drive_results_q.size() == 0) begin
          flag_error($sformatf("result with nothing outstanding: drive %0d average %0d",
                               out_mon.drive, out_mon.average));
        end else begin
          oldest = drive_results_q.pop_front();
          if (out_mon.drive !== oldest.drive) begin
            flag_error($sformatf("drive mismatch: got %0d, want %0d",
                                 out_mon.drive, oldest.drive));
          end
          if (out_mon.average !== oldest.average) begin
            flag_error($sformatf("average mismatch: got %0d, want %0d",
                                 out_mon.average, oldest.average));
          end
          if (out_mon.report_error !== oldest.report_error) begin
            flag_error($sformatf("report_error mismatch: got %0d, want %0d",
                                 out_mon.report_error, oldest.report_error));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        drive_results_q.push_back(compute_drive_step(in_mon.cmd, in_mon.sample));
      end
    end
  end

endmodule

// ===== sim/averaged_pid_drive_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_pid_drive_tb: stimulus and verdict for the averaged PID drive
// Runs a short directed set of samples and stops, then random samples under
// several register settings, including all-zero and all-maximum gains and
// runs of one error sign that build up the error accumulator both ways.
// Both channel sides idle at random; the checker beside the block compares.
// ----------------------------------------------------------------------------
module averaged_pid_drive_tb;
  import apd_pkg::*;

  localparam int   SAMPLE_BITS     = 12;
  localparam int   WINDOW          = 6;
  localparam int   SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
  localparam int   HOLD_OFF_CYCLES = 120;
  localparam int   SETTLE_CYCLES   = 12;
  localparam int   WATCHDOG_LIMIT  = 1000;
  localparam logic CMD_RUN         = 1'b0;
  localparam logic CMD_STOP        = 1'b1;

  logic clk_i;
  logic rst_ni;
  int   failures;
  int   outstanding;
  bit   quiet_run        = 1'b0;
  bit   hold_off_pending = 1'b0;
  int   cur_setpoint     = 0;

  apd_in_if #(.SampleBits(SAMPLE_BITS)) in_if ();
  apd_out_if                            out_if ();
  apd_cfg_if                            cfg_if ();

  averaged_pid_drive #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  apd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .failures_o    (failures),
    .outstanding_o (outstanding)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gain with a random number of significant bits.
  function automatic logic [GAIN_W-1:0] pick_gain();
    int bits;
    bits = $urandom_range(0, GAIN_W);
    return GAIN_W'($urandom) & ((GAIN_W'(1) << bits) - GAIN_W'(1));
  endfunction

  // Mix of extremes, readings near the setpoint and uniform readings.
  function automatic int pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2, 3, 4, 5: begin
        v = cur_setpoint + int'($urandom_range(0, 80)) - 40;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      end
      default: v = $urandom_range(0, SAMPLE_MAX);
    endcase
    return v;
  endfunction

  // Offers one sample transaction, sometimes after a gap, until it is taken.
  task automatic send_item(input logic cmd, input int sample);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.cmd    <= cmd;
    in_if.sample <= SAMPLE_BITS'(sample);
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
  endtask

  // Waits until every result is back and the block has settled.
  task automatic wait_drained();
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all registers while idle, plus one write to an unused index.
  task automatic set_config(input logic [SP_W-1:0] sp, input logic [GAIN_W-1:0] kp,
                            input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd);
    wait_drained();
    cfg_write(REG_SETPOINT, {12'($urandom), sp});
    cfg_write(REG_PROP_GAIN, kp);
    cfg_write(REG_INT_GAIN, gi);
    cfg_write(REG_DER_GAIN, gd);
    cfg_write(CFG_IDX_W'($urandom_range(int'(REG_DER_GAIN) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
    cur_setpoint = int'(sp);
  endtask

  task automatic run_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(CMD_STOP, $urandom_range(0, SAMPLE_MAX));
      end else begin
        send_item(CMD_RUN, pick_sample());
      end
    end
    in_if.valid <= 1'b0;
  endtask

  // A cleared start followed by a run of samples in one band, so the
  // error keeps one sign and the accumulator grows large.
  task automatic run_sustained(input int count, input int lo, input int hi);
    int k;
    send_item(CMD_STOP, $urandom_range(0, SAMPLE_MAX));
    for (k = 0; k < count; k++) begin
      send_item(CMD_RUN, $urandom_range(lo, hi));
    end
    in_if.valid <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin : result_acceptor
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Ends the run when no transaction has happened on any channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int p;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.cmd    <= CMD_RUN;
    in_if.sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_SETPOINT;
    cfg_if.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stop with an ignored sample, extremes, window fill, restart.
    set_config(12'd2000, 24'h010000, 24'h000100, 24'h008000);
    send_item(CMD_STOP, SAMPLE_MAX);
    send_item(CMD_RUN, 0);
    send_item(CMD_RUN, 0);
    repeat (6) send_item(CMD_RUN, SAMPLE_MAX);
    send_item(CMD_RUN, 2000);
    send_item(CMD_STOP, 0);
    send_item(CMD_RUN, 3000);
    in_if.valid <= 1'b0;

    // Directed: zero proportional gain forces a zero drive.
    set_config(12'd100, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
    send_item(CMD_RUN, SAMPLE_MAX);
    send_item(CMD_RUN, 0);
    send_item(CMD_RUN, 2048);
    in_if.valid <= 1'b0;

    // Directed: full proportional gain saturates the drive.
    set_config(12'd0, 24'hFFFFFF, 24'h000000, 24'h000000);
    send_item(CMD_RUN, SAMPLE_MAX);
    send_item(CMD_RUN, SAMPLE_MAX);
    send_item(CMD_RUN, 1);
    send_item(CMD_STOP, SAMPLE_MAX);
    in_if.valid <= 1'b0;

    // Directed: top setpoint gives a negative error and a clamped drive.
    set_config(12'd4095, 24'h010000, 24'h000000, 24'h000000);
    repeat (3) send_item(CMD_RUN, SAMPLE_MAX);
    in_if.valid <= 1'b0;

    // Random gains; the result side holds off long enough to stall the input.
    set_config(SP_W'($urandom), pick_gain(), pick_gain(), pick_gain());
    hold_off_pending = 1'b1;
    run_random(200);

    // All gains at maximum, then all gains zero.
    set_config(12'd4095, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    run_random(150);
    set_config(12'd0, 24'h000000, 24'h000000, 24'h000000);
    run_random(100);

    // Accumulator built up far in the positive and then the negative direction.
    set_config(12'd0, pick_gain(), pick_gain(), pick_gain());
    run_sustained(200, 3900, SAMPLE_MAX);
    set_config(12'd4095, pick_gain(), pick_gain(), pick_gain());
    run_sustained(200, 0, 195);

    // Further random settings.
    for (p = 0; p < 3; p++) begin
      set_config(SP_W'($urandom), pick_gain(), pick_gain(), pick_gain());
      run_random(250);
    end

    // Last part without any idling.
    quiet_run = 1'b1;
    set_config(SP_W'($urandom), pick_gain(), pick_gain(), pick_gain());
    run_random(200);

    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
